@@ design/bso_pkg.sv @@
// ----------------------------------------------------------------------------
// bso_pkg
// Shared constants and types for the box-sphere overlap mask block.
// ----------------------------------------------------------------------------
package bso_pkg;
  localparam int MAX_SPHERES = 1024;
  localparam int WORD_BITS   = 32;
  localparam int IDX_W       = $clog2(MAX_SPHERES);
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int WI_W        = IDX_W - BIT_W;
  localparam int CNT_W       = IDX_W + 1;
  localparam int QDEPTH      = 2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic               command;
    logic [IDX_W-1:0]   sphere_index;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        sphere_radius;
    logic signed [31:0] box_low_x;
    logic signed [31:0] box_low_y;
    logic signed [31:0] box_low_z;
    logic signed [31:0] box_high_x;
    logic signed [31:0] box_high_y;
    logic signed [31:0] box_high_z;
  } item_t;

  typedef struct packed {
    logic               is_load;
    item_t              item;
  } queue_entry_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        r;
  } sphere_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] hit_mask;
    logic [WI_W-1:0]      word_index;
    logic [CNT_W-1:0]     hit_count;
    logic                 last;
  } word_t;
endpackage

@@ design/bso_if.sv @@
// ----------------------------------------------------------------------------
// bso_in_if / bso_out_if
// Valid/ready channels for input items and result words.
// ----------------------------------------------------------------------------
interface bso_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [9:0]         sphere_index;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic [30:0]        sphere_radius;
  logic signed [31:0] box_low_x;
  logic signed [31:0] box_low_y;
  logic signed [31:0] box_low_z;
  logic signed [31:0] box_high_x;
  logic signed [31:0] box_high_y;
  logic signed [31:0] box_high_z;
  modport source(output valid, command, sphere_index, center_x, center_y, center_z,
                 sphere_radius, box_low_x, box_low_y, box_low_z, box_high_x,
                 box_high_y, box_high_z, input ready);
  modport sink(input valid, command, sphere_index, center_x, center_y, center_z,
               sphere_radius, box_low_x, box_low_y, box_low_z, box_high_x,
               box_high_y, box_high_z, output ready);
endinterface

interface bso_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hit_mask;
  logic [4:0]  word_index;
  logic [10:0] hit_count;
  logic        last;
  modport source(output valid, hit_mask, word_index, hit_count, last, input ready);
  modport sink(input valid, hit_mask, word_index, hit_count, last, output ready);
endinterface

@@ design/bso_front.sv @@
// ----------------------------------------------------------------------------
// bso_front
// Accepts input transactions, tags loads and queries, and queues them.
// ----------------------------------------------------------------------------
module bso_front import bso_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  item_t        in_item,
  output logic         head_valid,
  output queue_entry_t head,
  input  logic         pop
);
  localparam int PW = $clog2(QDEPTH);

  queue_entry_t     queue [QDEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      fill;
  logic             push;
  logic             do_pop;

  assign in_ready   = (fill != (PW+1)'(QDEPTH));
  assign push       = in_valid && in_ready;
  assign head_valid = (fill != '0);
  assign do_pop     = pop && head_valid;
  assign head       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr].is_load <= (in_item.command == CMD_LOAD);
      queue[wr_ptr].item    <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (PW+1)'(push) - (PW+1)'(do_pop);
    end
  end
endmodule

@@ design/bso_back.sv @@
// ----------------------------------------------------------------------------
// bso_back
// Sphere table, per-sphere overlap pipeline and mask word packing.
// ----------------------------------------------------------------------------
module bso_back import bso_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] sphere_count,
  input  logic             head_valid,
  input  queue_entry_t     head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output word_t            out_word
);
  sphere_t          mem [MAX_SPHERES];
  logic             adv;
  logic             busy;
  logic [CNT_W-1:0] n;
  logic [IDX_W-1:0] j;
  logic             pipe_empty;
  logic [CNT_W-1:0] n_sat;

  logic signed [31:0] lo [3];
  logic signed [31:0] hi [3];

  // stage 1: table read
  logic             p1_v, p1_last;
  logic [IDX_W-1:0] p1_j;
  sphere_t          p1_s;
  // stage 2: axis distances
  logic             p2_v, p2_last;
  logic [IDX_W-1:0] p2_j;
  logic [31:0]      p2_d [3];
  logic [30:0]      p2_r;
  // stage 3: squares
  logic             p3_v, p3_last;
  logic [IDX_W-1:0] p3_j;
  logic [63:0]      p3_sq [3];
  logic [61:0]      p3_r2;
  // stage 4: partial sum
  logic             p4_v, p4_last;
  logic [IDX_W-1:0] p4_j;
  logic [64:0]      p4_s01;
  logic [63:0]      p4_sq2;
  logic [61:0]      p4_r2;

  logic [WORD_BITS-1:0] mask;
  logic [CNT_W-1:0]     count;
  logic                 hit;
  logic [65:0]          total;
  logic [WORD_BITS-1:0] mask_next;
  logic [CNT_W-1:0]     count_next;
  logic [31:0]          c_ax [3];

  assign adv        = !out_valid || out_ready;
  assign pipe_empty = !p1_v && !p2_v && !p3_v && !p4_v;
  assign n_sat      = (sphere_count > CNT_W'(MAX_SPHERES)) ? CNT_W'(MAX_SPHERES)
                                                           : sphere_count;
  // wait for the pipeline to drain so a new box never meets old spheres
  assign pop        = head_valid && !busy && pipe_empty && adv;

  always_ff @(posedge clk) begin
    if (pop && head.is_load) begin
      mem[head.item.sphere_index] <= '{cx: head.item.center_x, cy: head.item.center_y,
                                       cz: head.item.center_z,
                                       r: head.item.sphere_radius};
    end
    if (adv && busy) p1_s <= mem[j];
  end

  always_ff @(posedge clk) begin
    if (pop && !head.is_load) begin
      lo[0] <= head.item.box_low_x;  hi[0] <= head.item.box_high_x;
      lo[1] <= head.item.box_low_y;  hi[1] <= head.item.box_high_y;
      lo[2] <= head.item.box_low_z;  hi[2] <= head.item.box_high_z;
      n     <= n_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      j    <= '0;
    end else if (pop && !head.is_load && (n_sat != '0)) begin
      busy <= 1'b1;
      j    <= '0;
    end else if (adv && busy) begin
      j <= j + 1'b1;
      if ({1'b0, j} == n - 1'b1) busy <= 1'b0;
    end
  end

  assign c_ax[0] = p1_s.cx;
  assign c_ax[1] = p1_s.cy;
  assign c_ax[2] = p1_s.cz;

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_j    <= j;
      p1_last <= ({1'b0, j} == n - 1'b1);
      p2_j    <= p1_j;
      p2_last <= p1_last;
      p2_r    <= p1_s.r;
      for (int a = 0; a < 3; a++) begin
        if ($signed(c_ax[a]) < lo[a])
          p2_d[a] <= 32'(33'(lo[a]) - 33'($signed(c_ax[a])));
        else if ($signed(c_ax[a]) > hi[a])
          p2_d[a] <= 32'(33'($signed(c_ax[a])) - 33'(hi[a]));
        else
          p2_d[a] <= '0;
      end
      p3_j    <= p2_j;
      p3_last <= p2_last;
      for (int a = 0; a < 3; a++) p3_sq[a] <= 64'(p2_d[a]) * 64'(p2_d[a]);
      p3_r2   <= 62'(p2_r) * 62'(p2_r);
      p4_j    <= p3_j;
      p4_last <= p3_last;
      p4_s01  <= 65'(p3_sq[0]) + 65'(p3_sq[1]);
      p4_sq2  <= p3_sq[2];
      p4_r2   <= p3_r2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0; p2_v <= 1'b0; p3_v <= 1'b0; p4_v <= 1'b0;
    end else if (adv) begin
      p1_v <= busy; p2_v <= p1_v; p3_v <= p2_v; p4_v <= p3_v;
    end
  end

  assign total      = 66'(p4_s01) + 66'(p4_sq2);
  assign hit        = (total < 66'(p4_r2));
  assign mask_next  = mask | (WORD_BITS'(hit) << p4_j[BIT_W-1:0]);
  assign count_next = count + CNT_W'(hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      mask  <= '0;
      count <= '0;
    end else if (pop) begin
      mask  <= '0;
      count <= '0;
    end else if (adv && p4_v) begin
      count <= count_next;
      // close the word at its top bit or at the final sphere
      if (p4_last || (p4_j[BIT_W-1:0] == BIT_W'(WORD_BITS-1))) mask <= '0;
      else mask <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && !head.is_load && (n_sat == '0)) begin
      out_valid <= 1'b1;
    end else if (adv && p4_v && (p4_last || (p4_j[BIT_W-1:0] == BIT_W'(WORD_BITS-1)))) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !head.is_load && (n_sat == '0)) begin
      out_word <= '{hit_mask: '0, word_index: '0, hit_count: '0, last: 1'b1};
    end else if (adv && p4_v && (p4_last || (p4_j[BIT_W-1:0] == BIT_W'(WORD_BITS-1)))) begin
      out_word <= '{hit_mask: mask_next, word_index: p4_j[IDX_W-1:BIT_W],
                    hit_count: count_next, last: p4_last};
    end
  end
endmodule

@@ design/box_sphere_overlap_mask.sv @@
// Timing: an accepted item is registered in the queue before it is popped. A load is
//   written at its pop edge. A query runs its spheres through the table read, distance,
//   square and partial-sum stages, where n is sphere_count saturated to 1024; for n of 0
//   the single word is valid at the pop edge. Sphere tests run one per cycle while the
//   output is not stalled; the back end pops no new item until a query has drained.
// Reset: rst (synchronous) clears sphere_count, the queue and the pipeline;
//   the sphere table is not cleared.
// ----------------------------------------------------------------------------
// box_sphere_overlap_mask
// Tests query boxes against a table of spheres and emits packed hit masks.
// ----------------------------------------------------------------------------
module box_sphere_overlap_mask import bso_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write_en,
  input  logic [10:0]  cfg_write_data,
  bso_in_if.sink       items,
  bso_out_if.source    results
);
  logic [CNT_W-1:0] sphere_count;
  item_t            in_item;
  queue_entry_t     head;
  logic             head_valid;
  logic             pop;
  word_t            out_word;

  always_ff @(posedge clk) begin
    if (rst) sphere_count <= '0;
    else if (cfg_write_en) sphere_count <= cfg_write_data;
  end

  assign in_item = '{command: items.command, sphere_index: items.sphere_index,
                     center_x: items.center_x, center_y: items.center_y,
                     center_z: items.center_z, sphere_radius: items.sphere_radius,
                     box_low_x: items.box_low_x, box_low_y: items.box_low_y,
                     box_low_z: items.box_low_z, box_high_x: items.box_high_x,
                     box_high_y: items.box_high_y, box_high_z: items.box_high_z};

  bso_front u_front (
    .clk(clk), .rst(rst), .in_valid(items.valid), .in_ready(items.ready),
    .in_item(in_item), .head_valid(head_valid), .head(head), .pop(pop)
  );

  bso_back u_back (
    .clk(clk), .rst(rst), .sphere_count(sphere_count), .head_valid(head_valid),
    .head(head), .pop(pop), .out_valid(results.valid), .out_ready(results.ready),
    .out_word(out_word)
  );

  assign results.hit_mask   = out_word.hit_mask;
  assign results.word_index = out_word.word_index;
  assign results.hit_count  = out_word.hit_count;
  assign results.last       = out_word.last;
endmodule

@@ design/bso_checker.sv @@
// ----------------------------------------------------------------------------
// bso_checker
// Port-level checks on the result channel of the overlap mask block.
// ----------------------------------------------------------------------------
module bso_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] hit_mask,
  input logic [4:0]  word_index,
  input logic [10:0] hit_count
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit_mask) && $stable(hit_count))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, hit_count} <= ({1'b0, word_index, 5'b0} + 12'd32)))
    else $error("hit count exceeds spheres covered");

  a_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($countones(hit_mask) <= hit_count))
    else $error("mask holds more hits than the count");
endmodule

bind box_sphere_overlap_mask bso_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(results.valid), .out_ready(results.ready),
  .hit_mask(results.hit_mask), .word_index(results.word_index),
  .hit_count(results.hit_count)
);
